FILE: sv/contiguous_fit_allocator_defines.svh
// Assertion macros for the contiguous fit allocator.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define CFA_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define CFA_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define CFA_ASSERT_IMP(label, clk, rst_n, a, c)
`define CFA_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: sv/cfa_pkg.sv
// Shared types and codes for the contiguous fit allocator.
`timescale 1ns / 1ps
package cfa_pkg;
    localparam logic [1:0] MODE_REQ = 2'd0;
    localparam logic [1:0] MODE_REL = 2'd1;
    localparam logic [1:0] MODE_CMP = 2'd2;
    localparam logic [1:0] MODE_DMP = 2'd3;

    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOSPACE = 3'd1;
    localparam logic [2:0] ST_NOOWNER = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_ZERO    = 3'd4;

    // address and owner tag widths are fixed by the stream field layout
    localparam int ADDR_BITS = 20;
    localparam int TAG_BITS  = 8;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_REQ_DEC,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_REQ_WR,
        S_REQ_REM,
        S_REL_RDN,
        S_REL_RDP,
        S_REL_CHK,
        S_REM_RD,
        S_REM_WR,
        S_REL_FIN,
        S_CMP_RD,
        S_CMP_WR,
        S_CMP_TAIL,
        S_DMP_RD,
        S_DMP_OUT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [TAG_BITS-1:0]  owner;
        logic [ADDR_BITS-1:0] base;
        logic [ADDR_BITS-1:0] last_addr;
        logic                 used;
        logic                 last;
    } result_t;
endpackage

FILE: sv/cfa_seg_ram.sv
// Segment table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module cfa_seg_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 49
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: sv/contiguous_fit_allocator.sv
// Top level of the contiguous fit allocator: sequencer around the segment table.
//
//  channel | dir | contents
//  s_axis  | in  | tdata: mode[1:0] process_tag[9:2] request_size[30:10] fit_policy[32:31]
//  m_axis  | out | tdata: status[2:0] owner_tag[10:3] seg_base[30:11] seg_end[50:31]
//          |     |        seg_used[51]; tlast: last
//  cfg     | in  | cfg_we, cfg_data: memory_size
//
// Request: scan the rows, then shift rows up for the split, then the grant and remainder
// writes. Release: look the owner up row by row, read both neighbors, write the merged
// row, then move the rows above it down in one pass. Compact packs the busy rows down,
// then writes the free tail; dump reads and emits each segment in turn, one row at a time.
// Reset and each memory_size write run a clearing pass over all MAX_SEGMENTS rows
// of the table; no command is taken during it.
// A stalled result holds the sequencer; input is taken only when idle.
`timescale 1ns / 1ps
`include "contiguous_fit_allocator_defines.svh"
module contiguous_fit_allocator #(
    parameter int MAX_SEGMENTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [20:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // mode, process_tag, request_size, fit_policy
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // status, owner_tag, seg_base, seg_end, seg_used
    output logic        m_axis_tlast    // last
);
    import cfa_pkg::*;

    localparam int IB = $clog2(MAX_SEGMENTS);
    localparam int CB = $clog2(MAX_SEGMENTS + 1);
    localparam int LB = ADDR_BITS + 1;
    localparam int W  = 2 * ADDR_BITS + 1 + TAG_BITS;
    localparam logic [LB-1:0] TOP = LB'(1) << ADDR_BITS;

    // row layout: {owner, busy, end, base}
    typedef struct packed {
        logic [TAG_BITS-1:0]  owner;
        logic                 busy;
        logic [ADDR_BITS-1:0] e;
        logic [ADDR_BITS-1:0] b;
    } row_t;

    state_t state_reg, state_next;
    logic [LB-1:0]       msize_reg;
    logic [CB-1:0]       count_reg, count_next;
    logic [CB-1:0]       idx_reg, idx_next;
    logic [CB-1:0]       wi_reg, wi_next;
    logic [CB-1:0]       pick_reg, pick_next;
    logic                found_reg, found_next;
    logic [LB-1:0]       plen_reg, plen_next;
    logic [LB-1:0]       pos_reg, pos_next;
    row_t                hold_reg, hold_next;
    row_t                cur_reg, cur_next;
    logic                pbusy_reg, pbusy_next;
    logic                cfg_pend_reg;
    logic [1:0]          mode_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [LB-1:0]       size_reg;
    logic [1:0]          pol_reg;
    result_t             res_reg, res_next;
    logic                ov_reg;
    logic                olast_reg;

    logic          we;
    logic [IB-1:0] waddr, raddr;
    row_t          wrow, rrow;
    logic [W-1:0]  rdata;

    cfa_seg_ram #(.DEPTH(MAX_SEGMENTS), .WIDTH(W)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wrow), .raddr(raddr), .rdata(rdata)
    );
    assign rrow = row_t'(rdata);

    logic [LB-1:0] rlen;
    assign rlen = LB'({1'b0, rrow.e}) - LB'({1'b0, rrow.b}) + LB'(1);

    // memory_size: zero acts as one, anything above the address space is capped
    logic [LB-1:0] cfg_clamped;
    always_comb
    begin
        cfg_clamped = cfg_data;
        if (cfg_data == 21'd0)
        begin
            cfg_clamped = LB'(1);
        end
        else if (cfg_data > TOP)
        begin
            cfg_clamped = TOP;
        end
    end

    logic out_free;
    assign out_free = !ov_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_pend_reg;

    function automatic result_t mk(input logic [2:0] st, input logic [TAG_BITS-1:0] t,
                                   input row_t r, input logic withrow, input logic lst);
        result_t x;
        x = '0;
        x.status = st;
        x.owner = t;
        if (withrow)
        begin
            x.base = r.b;
            x.last_addr = r.e;
            x.used = r.busy;
            x.owner = r.busy ? r.owner : '0;
        end
        x.last = lst;
        return x;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:     state_next = (idx_reg == CB'(MAX_SEGMENTS - 1)) ? S_IDLE : S_INIT;
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    unique case (s_axis_tdata[1:0])
                        MODE_REQ: state_next = (s_axis_tdata[30:10] == 21'd0) ? S_EMIT
                                                                              : S_SCAN_RD;
                        MODE_REL: state_next = S_SCAN_RD;
                        MODE_CMP: state_next = S_CMP_RD;
                        MODE_DMP: state_next = S_DMP_RD;
                    endcase
                end
            end
            S_SCAN_RD:  state_next = S_SCAN;
            S_SCAN:
            begin
                if (mode_reg == MODE_REL)
                begin
                    if (!rrow.busy || rrow.owner != tag_reg)
                        state_next = (idx_reg + CB'(1) >= count_reg) ? S_EMIT : S_SCAN_RD;
                    else
                        state_next = S_REL_RDN;
                end
                else if (found_next && pol_reg != POL_BEST && pol_reg != POL_WORST)
                    state_next = S_REQ_DEC;
                else if (idx_reg + CB'(1) >= count_reg)
                    state_next = found_next ? S_REQ_DEC : S_EMIT;
                else
                    state_next = S_SCAN_RD;
            end
            S_REQ_DEC:
            begin
                if (plen_reg == size_reg) state_next = S_REQ_WR;
                else if (count_reg >= CB'(MAX_SEGMENTS)) state_next = S_EMIT;
                else state_next = (count_reg == pick_reg + CB'(1)) ? S_REQ_WR : S_SHIFT_RD;
            end
            S_SHIFT_RD: state_next = S_SHIFT_WR;
            S_SHIFT_WR: state_next = (idx_reg == pick_reg + CB'(2)) ? S_REQ_WR : S_SHIFT_RD;
            S_REQ_WR:   state_next = (plen_reg != size_reg) ? S_REQ_REM : S_EMIT;
            S_REQ_REM:  state_next = S_EMIT;
            S_REL_RDN:  state_next = S_REL_RDP;
            S_REL_RDP:  state_next = S_REL_CHK;
            S_REL_CHK:  state_next = S_REM_RD;
            S_REM_RD:   state_next = S_REM_WR;
            S_REM_WR:   state_next = S_REM_RD;
            S_REL_FIN:  state_next = S_EMIT;
            S_CMP_RD:   state_next = S_CMP_WR;
            S_CMP_WR:   state_next = (idx_reg + CB'(1) >= count_reg) ? S_CMP_TAIL : S_CMP_RD;
            S_CMP_TAIL: state_next = S_EMIT;
            S_DMP_RD:   state_next = S_DMP_OUT;
            S_DMP_OUT:
                if (out_free)
                    state_next = (idx_reg + CB'(1) >= count_reg) ? S_IDLE : S_DMP_RD;
            S_EMIT:     if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
        if (state_reg == S_REL_CHK || state_reg == S_REM_WR)
        begin
            // removal steps are driven by wi_next below; REL_FIN when no row left to drop
            if (wi_next == '0) state_next = S_REL_FIN;
        end
    end

    // datapath and memory control
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        wi_next    = wi_reg;
        pick_next  = pick_reg;
        found_next = found_reg;
        plen_next  = plen_reg;
        pos_next   = pos_reg;
        hold_next  = hold_reg;
        cur_next   = cur_reg;
        pbusy_next = pbusy_reg;
        res_next   = res_reg;
        we    = 1'b0;
        waddr = idx_reg[IB-1:0];
        wrow  = '0;
        raddr = idx_reg[IB-1:0];
        unique case (state_reg)
            S_INIT:
            begin
                we = 1'b1;
                wrow.e = (idx_reg == '0) ? ADDR_BITS'(msize_reg - LB'(1)) : '0;
                idx_next = idx_reg + CB'(1);
                if (idx_reg == CB'(MAX_SEGMENTS - 1))
                begin
                    idx_next = '0;
                    count_next = CB'(1);
                end
            end
            S_IDLE:
            begin
                idx_next = '0;
                found_next = 1'b0;
                pos_next = '0;
                wi_next = '0;
                res_next = mk(ST_ZERO, s_axis_tdata[2 +: TAG_BITS], '0, 1'b0, 1'b1);
            end
            S_SCAN_RD: ;
            S_SCAN:
            begin
                if (mode_reg == MODE_REL)
                begin
                    res_next = mk(ST_NOOWNER, tag_reg, '0, 1'b0, 1'b1);
                    pick_next = idx_reg;
                    cur_next = rrow;
                    idx_next = idx_reg + CB'(1);
                end
                else
                begin
                    res_next = mk(ST_NOSPACE, tag_reg, '0, 1'b0, 1'b1);
                    if (!rrow.busy && rlen >= size_reg &&
                        (!found_reg || (pol_reg == POL_BEST && rlen < plen_reg) ||
                         (pol_reg == POL_WORST && rlen > plen_reg)))
                    begin
                        found_next = 1'b1;
                        pick_next = idx_reg;
                        plen_next = rlen;
                        cur_next = rrow;
                    end
                    idx_next = idx_reg + CB'(1);
                end
            end
            S_REQ_DEC:
            begin
                res_next = mk(ST_FULL, tag_reg, '0, 1'b0, 1'b1);
                idx_next = count_reg;
            end
            S_SHIFT_RD: raddr = IB'(idx_reg - CB'(1));
            S_SHIFT_WR:
            begin
                we = 1'b1;
                wrow = rrow;
                idx_next = idx_reg - CB'(1);
            end
            S_REQ_WR:
            begin
                we = 1'b1;
                waddr = pick_reg[IB-1:0];
                wrow = cur_reg;
                wrow.busy = 1'b1;
                wrow.owner = tag_reg;
                if (plen_reg != size_reg)
                begin
                    wrow.e = ADDR_BITS'(LB'(cur_reg.b) + size_reg - LB'(1));
                    count_next = count_reg + CB'(1);
                end
                res_next = mk(ST_OK, tag_reg, wrow, 1'b1, 1'b1);
            end
            S_REQ_REM:
            begin
                // free remainder lands just above the granted row
                we = 1'b1;
                waddr = IB'(pick_reg + CB'(1));
                wrow = '0;
                wrow.b = ADDR_BITS'(LB'(cur_reg.b) + size_reg);
                wrow.e = cur_reg.e;
            end
            S_REL_RDN: raddr = IB'(pick_reg + CB'(1));
            S_REL_RDP:
            begin
                raddr = IB'(pick_reg - CB'(1));
                // rrow is next row here
                hold_next = rrow;
                pbusy_next = (pick_reg + CB'(1) >= count_reg) ? 1'b1 : rrow.busy;
            end
            S_REL_CHK:
            begin
                // rrow is previous row; merged result kept in cur
                cur_next = cur_reg;
                cur_next.busy = 1'b0;
                cur_next.owner = '0;
                if (!pbusy_reg) cur_next.e = hold_reg.e;
                pos_next = '0;
                if (pick_reg != '0 && !rrow.busy)
                begin
                    cur_next.b = rrow.b;
                    pick_next = pick_reg - CB'(1);
                end
                // number of rows to drop above the merged one
                wi_next = CB'(!pbusy_reg) + CB'(pick_reg != '0 && !rrow.busy);
                idx_next = ((pick_reg != '0 && !rrow.busy) ? pick_reg - CB'(1) : pick_reg)
                           + CB'(1) + wi_next;
                we = 1'b1;
                waddr = IB'((pick_reg != '0 && !rrow.busy) ? pick_reg - CB'(1) : pick_reg);
                wrow = cur_next;
            end
            S_REM_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    raddr = '0;
                end
            end
            S_REM_WR:
            begin
                if (idx_reg < count_reg)
                begin
                    we = 1'b1;
                    waddr = IB'(idx_reg - wi_reg);
                    wrow = rrow;
                    idx_next = idx_reg + CB'(1);
                end
                else
                begin
                    count_next = count_reg - wi_reg;
                    wi_next = '0;
                end
            end
            S_REL_FIN: res_next = mk(ST_OK, tag_reg, cur_reg, 1'b1, 1'b1);
            S_CMP_RD: ;
            S_CMP_WR:
            begin
                idx_next = idx_reg + CB'(1);
                if (rrow.busy)
                begin
                    we = 1'b1;
                    waddr = wi_reg[IB-1:0];
                    wrow = rrow;
                    wrow.b = ADDR_BITS'(pos_reg);
                    wrow.e = ADDR_BITS'(pos_reg + rlen - LB'(1));
                    pos_next = pos_reg + rlen;
                    wi_next = wi_reg + CB'(1);
                    cur_next = wrow;
                end
            end
            S_CMP_TAIL:
            begin
                if (pos_reg < msize_reg || wi_reg == '0)
                begin
                    we = 1'b1;
                    waddr = wi_reg[IB-1:0];
                    wrow = '0;
                    wrow.b = ADDR_BITS'(pos_reg);
                    wrow.e = ADDR_BITS'(msize_reg - LB'(1));
                    count_next = wi_reg + CB'(1);
                    res_next = mk(ST_OK, tag_reg, wrow, 1'b1, 1'b1);
                end
                else
                begin
                    count_next = wi_reg;
                    res_next = mk(ST_OK, tag_reg, cur_reg, 1'b1, 1'b1);
                end
            end
            S_DMP_RD: ;
            S_DMP_OUT:
            begin
                res_next = mk(ST_OK, tag_reg, rrow, 1'b1, idx_reg + CB'(1) >= count_reg);
                if (out_free) idx_next = idx_reg + CB'(1);
            end
            S_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            idx_reg <= '0;
            count_reg <= CB'(1);
            msize_reg <= TOP;
            cfg_pend_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                msize_reg <= cfg_clamped;
                cfg_pend_reg <= 1'b1;
            end
            if (cfg_pend_reg && state_reg == S_IDLE && !cfg_we)
            begin
                state_reg <= S_INIT;
                idx_reg <= '0;
                cfg_pend_reg <= 1'b0;
            end
            else
            begin
                state_reg <= state_next;
                idx_reg <= idx_next;
                count_reg <= count_next;
            end
            if (ov_reg && m_axis_tready) ov_reg <= 1'b0;
            if ((state_reg == S_EMIT || state_reg == S_DMP_OUT) && out_free)
            begin
                ov_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wi_reg <= wi_next;
        pick_reg <= pick_next;
        found_reg <= found_next;
        plen_reg <= plen_next;
        pos_reg <= pos_next;
        hold_reg <= hold_next;
        cur_reg <= cur_next;
        pbusy_reg <= pbusy_next;
        res_reg <= res_next;
        if (state_reg == S_IDLE && s_axis_tvalid && s_axis_tready)
        begin
            mode_reg <= s_axis_tdata[1:0];
            tag_reg <= s_axis_tdata[2 +: TAG_BITS];
            size_reg <= (s_axis_tdata[30:10] > 21'(TOP)) ? TOP + LB'(1)
                                                        : LB'(s_axis_tdata[30:10]);
            pol_reg <= s_axis_tdata[32:31];
        end
        // a dump row is formed in the same cycle it is loaded into the output register
        if ((state_reg == S_EMIT || state_reg == S_DMP_OUT) && out_free)
        begin
            m_axis_tdata <= {4'd0, res_next.used, res_next.last_addr,
                             res_next.base, res_next.owner, res_next.status};
            olast_reg <= res_next.last;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tlast  = olast_reg;

    `CFA_ASSERT_NEXT(a_out_valid_held, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `CFA_ASSERT_NEXT(a_out_data_held, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `CFA_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg != '0 && count_reg <= CB'(MAX_SEGMENTS))
    `CFA_ASSERT_IMP(a_accept_idle, clk, rst_n, s_axis_tvalid && s_axis_tready, state_reg == S_IDLE)
endmodule

FILE: tb/tb_top.sv
// Testbench for the contiguous fit allocator: directed and random commands, table model.
`timescale 1ns / 1ps
module tb_top;
    import cfa_pkg::*;

    localparam int NSEG = 32;
    localparam int POL_FIRST = 0;
    localparam int POL_UNUSED = 3;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  owner;
        logic [19:0] base;
        logic [19:0] seg_end;
        logic        used;
        logic        last;
    } seg_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [20:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // mode, process_tag, request_size, fit_policy
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;       // status, owner_tag, seg_base, seg_end, seg_used
    logic        m_axis_tlast;       // last

    contiguous_fit_allocator dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always #4 clk = ~clk;

    // shadow segment table
    logic [20:0] tbl_base [NSEG+1];
    logic [20:0] tbl_end  [NSEG+1];
    logic        tbl_busy [NSEG+1];
    logic [7:0]  tbl_owner[NSEG+1];
    int          tbl_count;
    logic [20:0] mem_units;

    seg_report_t pending_reports[$];
    int          error_count = 0;
    int          stall_hold = 0;   // long receiver hold-off, in cycles
    bit          quiet_rx = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic seg_report_t seg_line(input int i, input logic lst);
        seg_report_t r;
        r.status  = ST_OK;
        r.owner   = tbl_busy[i] ? tbl_owner[i] : 8'd0;
        r.base    = tbl_base[i][19:0];
        r.seg_end = tbl_end[i][19:0];
        r.used    = tbl_busy[i];
        r.last    = lst;
        return r;
    endfunction

    function automatic seg_report_t err_line(input logic [2:0] st, input logic [7:0] tag);
        seg_report_t r;
        r = '0;
        r.status = st;
        r.owner = tag;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void table_clear(input logic [20:0] sz);
        mem_units = (sz == 0) ? 21'd1 : (sz > 21'h100000 ? 21'h100000 : sz);
        for (int i = 0; i <= NSEG; i++)
        begin
            tbl_base[i] = 0; tbl_end[i] = 0; tbl_busy[i] = 0; tbl_owner[i] = 0;
        end
        tbl_count = 1;
        tbl_end[0] = mem_units - 1;
    endfunction

    function automatic void drop_row(input int i);
        for (int j = i; j + 1 < tbl_count; j++)
        begin
            tbl_base[j] = tbl_base[j+1]; tbl_end[j] = tbl_end[j+1];
            tbl_busy[j] = tbl_busy[j+1]; tbl_owner[j] = tbl_owner[j+1];
        end
        tbl_count--;
    endfunction

    // Predict the reports one command produces and update the shadow table.
    function automatic void predict_command(input logic [1:0] mode, input logic [7:0] tag,
                                            input logic [20:0] size, input logic [1:0] pol);
        int pick, f, n;
        logic [20:0] plen, len, pos;
        pick = -1; plen = 0; f = -1; n = 0; pos = 0;
        case (mode)
            MODE_REQ:
            begin
                if (size == 0)
                begin
                    pending_reports.push_back(err_line(ST_ZERO, tag));
                    return;
                end
                for (int i = 0; i < tbl_count; i++)
                begin
                    len = tbl_end[i] - tbl_base[i] + 1;
                    if (tbl_busy[i] || len < size) continue;
                    if (pick < 0 || (pol == POL_BEST && len < plen) ||
                        (pol == POL_WORST && len > plen))
                    begin
                        pick = i; plen = len;
                        if (pol != POL_BEST && pol != POL_WORST) break;
                    end
                end
                if (pick < 0)
                begin
                    pending_reports.push_back(err_line(ST_NOSPACE, tag));
                    return;
                end
                if (plen > size)
                begin
                    if (tbl_count >= NSEG)
                    begin
                        pending_reports.push_back(err_line(ST_FULL, tag));
                        return;
                    end
                    for (int i = tbl_count; i > pick + 1; i--)
                    begin
                        tbl_base[i] = tbl_base[i-1]; tbl_end[i] = tbl_end[i-1];
                        tbl_busy[i] = tbl_busy[i-1]; tbl_owner[i] = tbl_owner[i-1];
                    end
                    tbl_count++;
                    tbl_base[pick+1] = tbl_base[pick] + size;
                    tbl_end[pick+1] = tbl_end[pick];
                    tbl_busy[pick+1] = 0; tbl_owner[pick+1] = 0;
                    tbl_end[pick] = tbl_base[pick] + size - 1;
                end
                tbl_busy[pick] = 1; tbl_owner[pick] = tag;
                pending_reports.push_back(seg_line(pick, 1'b1));
            end
            MODE_REL:
            begin
                for (int i = 0; i < tbl_count; i++)
                    if (f < 0 && tbl_busy[i] && tbl_owner[i] == tag) f = i;
                if (f < 0)
                begin
                    pending_reports.push_back(err_line(ST_NOOWNER, tag));
                    return;
                end
                tbl_busy[f] = 0; tbl_owner[f] = 0;
                if (f + 1 < tbl_count && !tbl_busy[f+1])
                begin
                    tbl_end[f] = tbl_end[f+1];
                    drop_row(f + 1);
                end
                if (f > 0 && !tbl_busy[f-1])
                begin
                    tbl_end[f-1] = tbl_end[f];
                    drop_row(f);
                    f--;
                end
                pending_reports.push_back(seg_line(f, 1'b1));
            end
            MODE_CMP:
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (!tbl_busy[i]) continue;
                    len = tbl_end[i] - tbl_base[i] + 1;
                    tbl_base[n] = pos; tbl_end[n] = pos + len - 1;
                    tbl_busy[n] = 1; tbl_owner[n] = tbl_owner[i];
                    pos += len; n++;
                end
                if (pos < mem_units || n == 0)
                begin
                    tbl_base[n] = pos; tbl_end[n] = mem_units - 1;
                    tbl_busy[n] = 0; tbl_owner[n] = 0;
                    n++;
                end
                tbl_count = n;
                pending_reports.push_back(seg_line(n - 1, 1'b1));
            end
            default:
                for (int i = 0; i < tbl_count; i++)
                    pending_reports.push_back(seg_line(i, i == tbl_count - 1));
        endcase
    endfunction

    function automatic int short_or_long_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one command; the prediction is made when the transfer happens.
    // tvalid stays up between back-to-back commands and drops only for a gap.
    task automatic send_command(input logic [1:0] mode, input logic [7:0] tag,
                                input logic [20:0] size, input logic [1:0] pol);
        int gap;
        gap = short_or_long_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= {7'd0, pol, size, tag, mode};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        predict_command(mode, tag, size, pol);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (150) @(posedge clk);
    endtask

    task automatic write_size(input logic [20:0] sz);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= sz;
        @(posedge clk);
        cfg_we <= 1'b0;
        table_clear(sz);
    endtask

    // Receiver: random ready with occasional long hold-offs.
    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (quiet_rx)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= (short_or_long_gap() == 0) || ($urandom_range(0, 3) != 0);
    end

    // Result checker
    always @(posedge clk)
    begin
        seg_report_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = m_axis_tdata[2:0];
            got.owner = m_axis_tdata[10:3];
            got.base = m_axis_tdata[30:11];
            got.seg_end = m_axis_tdata[50:31];
            got.used = m_axis_tdata[51];
            got.last = m_axis_tlast;
            if (pending_reports.size() == 0)
                report_mismatch("unexpected result", 64'(got), 64'd0);
            else
            begin
                want = pending_reports.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.owner !== want.owner)
                    report_mismatch("owner_tag", 64'(got.owner), 64'(want.owner));
                if (got.base !== want.base)
                    report_mismatch("seg_base", 64'(got.base), 64'(want.base));
                if (got.seg_end !== want.seg_end)
                    report_mismatch("seg_end", 64'(got.seg_end), 64'(want.seg_end));
                if (got.used !== want.used)
                    report_mismatch("seg_used", 64'(got.used), 64'(want.used));
                if (got.last !== want.last)
                    report_mismatch("tlast", 64'(got.last), 64'(want.last));
            end
        end
    end

    task automatic test_directed();
        send_command(MODE_DMP, 8'd0, 21'd0, 2'd0);
        send_command(MODE_REQ, 8'hFF, 21'd0, 2'd0);               // zero size
        send_command(MODE_REQ, 8'd1, 21'h1FFFFF, 2'd0);           // too big
        send_command(MODE_REQ, 8'd1, 21'd100, POL_FIRST[1:0]);
        send_command(MODE_REQ, 8'd2, 21'd50, POL_BEST);
        send_command(MODE_REQ, 8'd3, 21'd200, POL_WORST);
        send_command(MODE_REQ, 8'd2, 21'd30, POL_UNUSED[1:0]);    // duplicate owner
        send_command(MODE_REL, 8'd2, 21'd0, 2'd0);                // lowest of two
        send_command(MODE_REL, 8'd77, 21'd0, 2'd0);               // unknown owner
        send_command(MODE_REQ, 8'd4, 21'd40, POL_BEST);           // best fit into hole
        send_command(MODE_REL, 8'd1, 21'd0, 2'd0);
        send_command(MODE_CMP, 8'd0, 21'd0, 2'd0);
        send_command(MODE_DMP, 8'hAA, 21'h155555, 2'd3);
        write_size(21'd1);                                         // smallest memory
        send_command(MODE_REQ, 8'd9, 21'd1, 2'd0);                 // exact fit
        send_command(MODE_CMP, 8'd0, 21'd0, 2'd0);                 // memory full
        send_command(MODE_REQ, 8'd9, 21'd1, 2'd0);
        send_command(MODE_REL, 8'd9, 21'd0, 2'd0);
        write_size(21'd0);                                         // acts as one
        send_command(MODE_DMP, 8'd0, 21'd0, 2'd0);
        write_size(21'h1FFFFF);                                    // clamps to max
        send_command(MODE_REQ, 8'h55, 21'h100000, 2'd0);
        send_command(MODE_DMP, 8'd0, 21'd0, 2'd0);
    endtask

    // Fill the table past its row limit to hit the table full status.
    task automatic test_table_full();
        write_size(21'd1000);
        for (int i = 0; i < 34; i++)
            send_command(MODE_REQ, i[7:0], 21'd3, 2'($urandom_range(0, 3)));
        send_command(MODE_DMP, 8'd0, 21'd0, 2'd0);
        for (int i = 0; i < 33; i += 2)
            send_command(MODE_REL, i[7:0], 21'd0, 2'd0);
        send_command(MODE_REQ, 8'd200, 21'd2, POL_BEST);
        send_command(MODE_CMP, 8'd0, 21'd0, 2'd0);
        send_command(MODE_DMP, 8'd0, 21'd0, 2'd0);
    endtask

    // Hold the output off while commands keep coming.
    task automatic test_backpressure();
        stall_hold = 400;
        for (int i = 0; i < 6; i++)
            send_command(MODE_DMP, 8'd0, 21'd0, 2'd0);
    endtask

    task automatic test_random(input int count, input logic [20:0] sz);
        int r;
        logic [20:0] rsize;
        write_size(sz);
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            rsize = ($urandom_range(0, 9) == 0) ? 21'($urandom) :
                    21'($urandom_range(1, (sz > 16) ? sz / 8 : 2));
            if (r < 50)
                send_command(MODE_REQ, 8'($urandom_range(0, 15)), rsize,
                             2'($urandom_range(0, 3)));
            else if (r < 80)
                send_command(MODE_REL, ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                             8'($urandom_range(0, 15)), 21'($urandom), 2'($urandom));
            else if (r < 90)
                send_command(MODE_CMP, 8'($urandom), 21'($urandom), 2'($urandom));
            else
                send_command(MODE_DMP, 8'($urandom), 21'($urandom), 2'($urandom));
        end
    endtask

    initial
    begin
        table_clear(21'h100000);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (40) @(posedge clk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random(40, 21'd64);
        test_random(40, 21'd5000);
        test_random(40, 21'h100000);
        test_random(20, 21'd2);
        wait_idle();
        if (error_count == 0 && pending_reports.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/cfa_pkg.sv
sv/cfa_seg_ram.sv
sv/contiguous_fit_allocator.sv
tb/tb_top.sv
